### src/pen_pkg.sv
// ----------------------------------------------------------------------------
// pen_pkg: shared types and constants for the playlist navigator
// Table geometry, word layouts, opcodes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pen_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 128;
  localparam int TRACK_WIDTH = 7;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W       = TRACK_WIDTH + 1;   // {enable, track}
  localparam int CMP_W       = 9;                 // holds MAX_ENTRIES and any 8-bit field

  // input word fields
  localparam int OPCODE_W          = 3;
  localparam int LIST_COUNT_W      = 8;
  localparam int ENTRY_INDEX_W     = 7;
  localparam int ENTRY_TRACK_W     = 7;
  localparam int LIST_COUNT_LSB    = 0;
  localparam int ENTRY_INDEX_LSB   = 8;
  localparam int ENTRY_TRACK_LSB   = 15;
  localparam int ENTRY_ENABLE_LSB  = 22;
  localparam int IN_TDATA_W        = 24;
  localparam int IN_TUSER_W        = OPCODE_W;

  // result word fields
  localparam int TRACK_FIELD_W = 7;
  localparam int POS_FIELD_W   = 7;
  localparam int TRACK_LSB     = 0;
  localparam int FOUND_LSB     = 7;
  localparam int POSITION_LSB  = 8;
  localparam int OUT_TDATA_W   = 16;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_LOOP_ENABLE = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_WRITE   = 3'd1,
    OP_NEXT    = 3'd2,
    OP_PREV    = 3'd3,
    OP_FIRST   = 3'd4,
    OP_CURRENT = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic start;     // word accepted this cycle
    logic fill;      // default fill sweep running
    logic scan;      // search running
    logic capture;   // take read data for current
    logic load_out;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic scan_hit;
    logic scan_empty;
    logic out_free;
  } status_t;

endpackage

### src/pen_ram.sv
// ----------------------------------------------------------------------------
// pen_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/pen_regs.sv
// ----------------------------------------------------------------------------
// pen_regs: configuration register block
// APB-style slave holding the loop enable bit.
// ----------------------------------------------------------------------------
module pen_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pen_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pen_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pen_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           loop_enable_o
);
  import pen_pkg::*;

  logic loop_enable_q;
  logic loop_enable_d;
  logic sel_loop;

  assign pready   = 1'b1;
  assign sel_loop = (paddr[APB_ADDR_W-1:2] == REG_LOOP_ENABLE);

  always_comb begin
    loop_enable_d = loop_enable_q;
    if (psel && penable && pwrite && pready && sel_loop) begin
      loop_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_enable_q <= 1'b0;
    end else begin
      loop_enable_q <= loop_enable_d;
    end
  end

  assign prdata        = sel_loop ? {{(APB_DATA_W-1){1'b0}}, loop_enable_q} : '0;
  assign loop_enable_o = loop_enable_q;

endmodule

### src/pen_ctrl.sv
// ----------------------------------------------------------------------------
// pen_ctrl: operation sequencer
// Decodes the opcode of an accepted word and steps the datapath through
// fill, search, read and result hand-off.
// ----------------------------------------------------------------------------
module pen_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  input  logic [pen_pkg::IN_TUSER_W-1:0] opcode_i,
  output logic                           s_ready_o,
  input  pen_pkg::status_t               sts_i,
  output pen_pkg::cmd_t                  cmd_o
);
  import pen_pkg::*;

  state_e state_q;
  state_e state_d;
  op_e    op;

  assign op = op_e'(opcode_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          unique case (op)
            OP_CREATE:                   state_d = ST_FILL;
            OP_NEXT, OP_PREV, OP_FIRST:  state_d = ST_SCAN;
            OP_CURRENT:                  state_d = ST_READ;
            default:                     state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (sts_i.fill_done) state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_empty) state_d = ST_DONE;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o        = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.op         = op;
    cmd_o.start      = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.fill       = (state_q == ST_FILL);
    cmd_o.scan       = (state_q == ST_SCAN);
    cmd_o.capture    = (state_q == ST_READ);
    cmd_o.load_out   = (state_q == ST_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/pen_dpath.sv
// ----------------------------------------------------------------------------
// pen_dpath: navigator datapath
// Entry table RAM with per-entry valid bits, count and position, the
// search walker (one table read per cycle) and the output register.
// ----------------------------------------------------------------------------
module pen_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pen_pkg::cmd_t                   cmd_i,
  output pen_pkg::status_t                sts_o,
  input  logic [pen_pkg::IN_TDATA_W-1:0]  s_data_i,
  input  logic                            loop_enable_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [pen_pkg::OUT_TDATA_W-1:0] m_data_o
);
  import pen_pkg::*;

  // unpacked input fields
  logic [LIST_COUNT_W-1:0]  list_count;
  logic [ENTRY_INDEX_W-1:0] entry_index;
  logic [ENTRY_TRACK_W-1:0] entry_track;
  logic                     entry_enable;

  // control state
  logic [CNT_W-1:0]       count_q;
  logic [IDX_W-1:0]       pos_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]       walk_q;
  logic [CNT_W-1:0]       rem_q;
  logic                   down_q;
  logic                   wrap_q;
  logic                   rd_pend_q;
  logic [CNT_W-1:0]       fill_q;
  logic [CNT_W-1:0]       fill_n_q;
  logic                   out_valid_q;

  // payload
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     rd_vld_q;
  logic [TRACK_WIDTH-1:0]   res_trk_q;
  logic                     res_found_q;
  logic [TRACK_FIELD_W-1:0] out_trk_q;
  logic                     out_found_q;
  logic [POS_FIELD_W-1:0]   out_pos_q;

  // table access
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic [CNT_W-1:0]       lc_sat;
  logic [CNT_W-1:0]       prev_init;
  logic                   wr_entry;
  logic                   fill_wr;
  logic [CNT_W-1:0]       walk_inc;
  logic [CNT_W-1:0]       jn;
  logic                   brk;
  logic                   can_step;
  logic                   issue;
  logic                   scan_hit;
  logic                   hit_take;
  logic                   ent_en;
  logic [TRACK_WIDTH-1:0] ent_trk;

  assign list_count   = s_data_i[LIST_COUNT_LSB +: LIST_COUNT_W];
  assign entry_index  = s_data_i[ENTRY_INDEX_LSB +: ENTRY_INDEX_W];
  assign entry_track  = s_data_i[ENTRY_TRACK_LSB +: ENTRY_TRACK_W];
  assign entry_enable = s_data_i[ENTRY_ENABLE_LSB];

  // count saturates at the table size
  assign lc_sat = (CMP_W'(list_count) > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : CNT_W'(list_count);
  // previous starts no further out than the end of the list
  assign prev_init = (CNT_W'(pos_q) > count_q) ? count_q : CNT_W'(pos_q);

  assign wr_entry = cmd_i.start && (cmd_i.op == OP_WRITE) &&
                    (CMP_W'(entry_index) < CMP_W'(MAX_ENTRIES));
  assign fill_wr  = cmd_i.fill && (fill_q != fill_n_q);

  always_comb begin
    ram_we    = fill_wr || wr_entry;
    ram_waddr = fill_wr ? fill_q[IDX_W-1:0] : IDX_W'(entry_index);
    ram_wdata = fill_wr ? {1'b1, TRACK_WIDTH'(fill_q + CNT_W'(1))}
                        : {entry_enable, TRACK_WIDTH'(entry_track)};
  end

  // next candidate of the walk
  always_comb begin
    walk_inc = walk_q + CNT_W'(1);
    if (down_q) begin
      if (walk_q == '0) begin
        brk = ~wrap_q;
        jn  = count_q - CNT_W'(1);
      end else begin
        brk = 1'b0;
        jn  = walk_q - CNT_W'(1);
      end
    end else begin
      if (walk_inc >= count_q) begin
        brk = ~wrap_q;
        jn  = '0;
      end else begin
        brk = 1'b0;
        jn  = walk_inc;
      end
    end
  end

  assign ent_en   = rd_vld_q & ram_rdata[TRACK_WIDTH];
  assign ent_trk  = rd_vld_q ? ram_rdata[TRACK_WIDTH-1:0] : '0;
  assign scan_hit = rd_pend_q & ent_en;
  assign hit_take = cmd_i.scan & scan_hit;
  assign can_step = (rem_q != '0) & ~brk;
  assign issue    = cmd_i.scan & can_step & ~scan_hit;

  assign ram_re    = issue || (cmd_i.start && (cmd_i.op == OP_CURRENT));
  assign ram_raddr = issue ? jn[IDX_W-1:0] : pos_q;

  pen_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      valid_q     <= '0;
      walk_q      <= '0;
      rem_q       <= '0;
      down_q      <= 1'b0;
      wrap_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      fill_q      <= '0;
      fill_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (cmd_i.start) begin
        unique case (cmd_i.op)
          OP_CREATE: begin
            count_q  <= lc_sat;
            pos_q    <= '0;
            fill_q   <= '0;
            fill_n_q <= lc_sat;
          end
          OP_NEXT: begin
            walk_q <= CNT_W'(pos_q);
            rem_q  <= count_q;
            down_q <= 1'b0;
            wrap_q <= loop_enable_i;
          end
          OP_PREV: begin
            walk_q <= prev_init;
            rem_q  <= count_q;
            down_q <= 1'b1;
            wrap_q <= loop_enable_i;
          end
          OP_FIRST: begin
            walk_q <= '1;          // one below entry 0
            rem_q  <= count_q;
            down_q <= 1'b0;
            wrap_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (fill_wr) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (issue) begin
        walk_q <= jn;
        rem_q  <= rem_q - CNT_W'(1);
      end
      if (hit_take) begin
        pos_q <= rd_idx_q;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      out_valid_q <= cmd_i.load_out | (out_valid_q & ~m_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_idx_q <= ram_raddr;
      rd_vld_q <= valid_q[ram_raddr];
    end
    if (cmd_i.start) begin
      res_trk_q   <= '0;
      res_found_q <= 1'b0;
    end
    if (cmd_i.capture || hit_take) begin
      res_trk_q   <= ent_trk;
      res_found_q <= ent_en;
    end
    if (cmd_i.load_out) begin
      out_trk_q   <= TRACK_FIELD_W'(res_trk_q);
      out_found_q <= res_found_q;
      out_pos_q   <= POS_FIELD_W'(pos_q);
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.fill_done  = (fill_q == fill_n_q);
    sts_o.scan_hit   = scan_hit;
    sts_o.scan_empty = ~rd_pend_q & ~can_step;
    sts_o.out_free   = ~out_valid_q | m_ready_i;
  end

  assign m_valid_o = out_valid_q;
  always_comb begin
    m_data_o = '0;
    m_data_o[TRACK_LSB +: TRACK_FIELD_W]  = out_trk_q;
    m_data_o[FOUND_LSB]                   = out_found_q;
    m_data_o[POSITION_LSB +: POS_FIELD_W] = out_pos_q;
  end

endmodule

### src/playlist_enabled_entry_navigator_core.sv
// ----------------------------------------------------------------------------
// playlist_enabled_entry_navigator_core: playlist table with enabled-entry
// navigation
// Top level: register port, sequencer and datapath.
// ----------------------------------------------------------------------------
// Holds a table of playlist entries (track number plus enable bit), an entry
// count and a current position. Each word on the input stream carries one
// operation: create a default list, write one entry, step to the next or
// previous enabled entry (wrapping at the ends only when loop_enable is set),
// go to the first enabled entry, or read the current one. Every operation
// returns exactly one result word: track, found flag and the position after
// the operation; a failed search returns track 0, found 0 and leaves the
// position alone. One operation is in progress at a time. Searches visit one
// table entry per cycle through the table RAM's single read port. A finished
// result sits in an output register, and the next word is taken while it
// waits. The table reads as all-zero after reset at once (per-entry valid
// flops), so there is no clearing pass. loop_enable lives at byte address 0
// and should only be written between operations.
module playlist_enabled_entry_navigator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] list_count, [14:8] entry_index, [21:15] entry_track, [22] entry_enable
  input  logic [pen_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  logic [pen_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [6:0] track, [7] found, [14:8] position
  output logic [pen_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pen_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pen_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pen_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pen_pkg::*;

  logic    loop_enable;
  cmd_t    cmd;
  status_t sts;

  // loop enable register
  pen_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .loop_enable_o (loop_enable)
  );

  // sequencer: owns input ready, drives the datapath
  pen_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .opcode_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // table, walker and output register
  pen_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_data_i      (s_axis_tdata),
    .loop_enable_i (loop_enable),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata)
  );

endmodule

### src/pen_checker.sv
// ----------------------------------------------------------------------------
// pen_checker: port-level checks for the playlist navigator
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module pen_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [pen_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pen_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one operation at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while an operation is in progress");

  // ready only falls because a word was taken
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without an accept");

  // a fresh result only comes out of a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an operation in progress");

endmodule

bind playlist_enabled_entry_navigator_core pen_checker u_pen_checker (.*);
